// File: design/plc_pkg.sv
package plc_pkg;

    localparam int FAIL_THRESHOLD = 5;
    localparam int MAX_PIN_CHARS  = 8;

    localparam int PIN_BYTES     = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int IDLE_MS_W     = 26;

    localparam logic [9:0]  LOCKOUT_BASE      = 10'd30;
    localparam logic [7:0]  LOCKOUT_MAX_SHIFT = 8'd5;
    localparam logic [7:0]  FAIL_SATURATE     = 8'd255;
    localparam logic [15:0] TMO_IMMEDIATE     = 16'hFFFF;
    localparam logic [9:0]  MS_PER_SECOND     = 10'd1000;
    localparam logic [3:0]  MIN_PIN_CHARS     = 4'd4;
    localparam logic [7:0]  CHAR_ZERO         = 8'h30;
    localparam logic [7:0]  CHAR_NINE         = 8'h39;

    typedef enum logic [3:0] {
        CMD_VERIFY      = 4'd0,
        CMD_SET         = 4'd1,
        CMD_CLEAR       = 4'd2,
        CMD_LOCK        = 4'd3,
        CMD_UNLOCK      = 4'd4,
        CMD_SLEEP_WAKE  = 4'd5,
        CMD_IDLE_CHECK  = 4'd6,
        CMD_SECOND_TICK = 4'd7,
        CMD_POWER_UP    = 4'd8
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCK_ON_BOOT       = 3'd0,
        CFG_LOCK_ON_SLEEP      = 3'd1,
        CFG_SLEEP_LOCK_SECONDS = 3'd2,
        CFG_IDLE_LOCK_ENABLE   = 3'd3,
        CFG_IDLE_LOCK_SECONDS  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [3:0]  command;
        logic [63:0] pin_chars;
        logic [3:0]  pin_length;
        logic [31:0] elapsed_seconds;
        logic [31:0] idle_ms;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic        is_locked;
        logic        pin_present;
        logic [7:0]  failures;
        logic [9:0]  lockout_left;
        logic        screen_change;
    } out_item_t;

    typedef struct packed {
        logic                 lock_on_boot;
        logic                 lock_on_sleep;
        logic [15:0]          sleep_lock_seconds;
        logic                 idle_lock_enable;
        logic [15:0]          idle_lock_seconds;
        logic [IDLE_MS_W-1:0] idle_lock_ms;
    } cfg_t;

    typedef struct packed {
        logic        locked;
        logic        pin_valid;
        logic [63:0] stored_pin;
        logic [3:0]  stored_length;
        logic [7:0]  fail_count;
        logic [9:0]  lockout_left;
    } state_t;

    // 30 << min(fails - threshold, 5), zero below the threshold
    function automatic logic [9:0] lockout_for(input logic [7:0] fails);
        logic [7:0] over;
        logic [9:0] secs;
        secs = '0;
        over = '0;
        if (fails >= 8'(FAIL_THRESHOLD)) begin
            over = fails - 8'(FAIL_THRESHOLD);
            if (over > LOCKOUT_MAX_SHIFT) begin
                over = LOCKOUT_MAX_SHIFT;
            end
            secs = LOCKOUT_BASE << over[2:0];
        end
        return secs;
    endfunction

    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        for (int i = 0; i < PIN_BYTES; i++) begin
            m[i*8 +: 8] = (4'(i) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// File: design/pin_lockout_controller_core.sv
// Channel  | Ports                                   | Carries
// ---------+-----------------------------------------+------------------------------
// input    | s_valid, s_ready, s_data                | command request (in_item_t)
// result   | m_valid, m_ready, m_data                | one result per request
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | policy register writes
//
// Two register stages: an input register, then the command logic and the
// lock state update, combinational, into the result register.
// One request per cycle sustained while m_ready is high; m_valid rises
// once a request has passed both registers. m_ready low holds the result
// register; the input register takes one more request, then s_ready drops.
// Synchronous active-low reset clears lock state, policy registers and valids.
// cfg_ready is always high.
module pin_lockout_controller_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  plc_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output plc_pkg::out_item_t              m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [plc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [plc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import plc_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    state_t    state_reg;
    state_t    state_next;
    out_item_t result;
    cfg_t      cfg;
    logic      out_free;
    logic      advance;

    plc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    plc_cmd_unit u_cmd (
        .item    (in_item_reg),
        .st      (state_reg),
        .cfg     (cfg),
        .st_next (state_next),
        .result  (result)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    // stored_pin is only read while pin_valid is set, so it needs no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.locked        <= 1'b0;
            state_reg.pin_valid     <= 1'b0;
            state_reg.stored_length <= '0;
            state_reg.fail_count    <= '0;
            state_reg.lockout_left  <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule

// File: design/plc_cfg_regs.sv
module plc_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [plc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [plc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output plc_pkg::cfg_t                   cfg
);
    import plc_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    // idle threshold is kept in ms so the compare path carries no multiplier
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (cfg_index)
                CFG_LOCK_ON_BOOT:       cfg_reg.lock_on_boot       <= cfg_data[0];
                CFG_LOCK_ON_SLEEP:      cfg_reg.lock_on_sleep      <= cfg_data[0];
                CFG_SLEEP_LOCK_SECONDS: cfg_reg.sleep_lock_seconds <= cfg_data;
                CFG_IDLE_LOCK_ENABLE:   cfg_reg.idle_lock_enable   <= cfg_data[0];
                CFG_IDLE_LOCK_SECONDS: begin
                    cfg_reg.idle_lock_seconds <= cfg_data;
                    cfg_reg.idle_lock_ms      <= IDLE_MS_W'(cfg_data)
                                                 * IDLE_MS_W'(MS_PER_SECOND);
                end
                default: ;
            endcase
        end
    end

endmodule

// File: design/plc_cmd_unit.sv
module plc_cmd_unit (
    input  plc_pkg::in_item_t  item,
    input  plc_pkg::state_t    st,
    input  plc_pkg::cfg_t      cfg,
    output plc_pkg::state_t    st_next,
    output plc_pkg::out_item_t result
);
    import plc_pkg::*;

    logic [PIN_BYTES-1:0] byte_eq;
    logic [PIN_BYTES-1:0] byte_digit;
    logic       pin_match;
    logic       pin_ok;
    logic       vf_run;
    logic       vf_ok;
    logic [7:0] fail_inc;
    logic [9:0] lock_new;
    logic [7:0] vf_fail;
    logic [9:0] vf_lockout;
    logic       ok;
    logic       screen;

    always_comb begin
        for (int i = 0; i < PIN_BYTES; i++) begin
            byte_eq[i]    = (4'(i) >= item.pin_length)
                            || (item.pin_chars[i*8 +: 8] == st.stored_pin[i*8 +: 8]);
            byte_digit[i] = (4'(i) >= item.pin_length)
                            || ((item.pin_chars[i*8 +: 8] >= CHAR_ZERO)
                                && (item.pin_chars[i*8 +: 8] <= CHAR_NINE));
        end
    end

    assign pin_match = (item.pin_length == st.stored_length)
                       && (item.pin_length <= 4'(PIN_BYTES)) && (&byte_eq);
    assign pin_ok    = (item.pin_length >= MIN_PIN_CHARS)
                       && (item.pin_length <= 4'(MAX_PIN_CHARS))
                       && (item.pin_length <= 4'(PIN_BYTES)) && (&byte_digit);

    // verify outcome, shared by verify and clear
    assign vf_run   = st.pin_valid && (st.lockout_left == '0);
    assign fail_inc = (st.fail_count == FAIL_SATURATE) ? FAIL_SATURATE
                                                       : st.fail_count + 8'd1;
    assign lock_new = lockout_for(fail_inc);

    always_comb begin
        vf_ok      = 1'b0;
        vf_fail    = st.fail_count;
        vf_lockout = st.lockout_left;
        if (vf_run) begin
            if (pin_match) begin
                vf_ok      = 1'b1;
                vf_fail    = '0;
                vf_lockout = '0;
            end else begin
                vf_fail = fail_inc;
                if (lock_new != '0) begin
                    vf_lockout = lock_new;
                end
            end
        end
    end

    always_comb begin
        st_next = st;
        ok      = 1'b0;
        screen  = 1'b0;
        unique case (cmd_t'(item.command))
            CMD_VERIFY: begin
                st_next.fail_count   = vf_fail;
                st_next.lockout_left = vf_lockout;
                ok                   = vf_ok;
            end
            CMD_SET: begin
                if (pin_ok) begin
                    st_next.stored_pin    = item.pin_chars & byte_mask(item.pin_length);
                    st_next.stored_length = item.pin_length;
                    st_next.pin_valid     = 1'b1;
                    st_next.fail_count    = '0;
                    st_next.lockout_left  = '0;
                    ok                    = 1'b1;
                end
            end
            CMD_CLEAR: begin
                if (!st.pin_valid) begin
                    ok = 1'b1;
                end else begin
                    st_next.fail_count   = vf_fail;
                    st_next.lockout_left = vf_lockout;
                    if (vf_ok) begin
                        st_next.pin_valid     = 1'b0;
                        st_next.stored_pin    = '0;
                        st_next.stored_length = '0;
                        st_next.locked        = 1'b0;
                        ok                    = 1'b1;
                    end
                end
            end
            CMD_LOCK: begin
                if (st.pin_valid) begin
                    st_next.locked = 1'b1;
                end
            end
            CMD_UNLOCK: begin
                st_next.locked = 1'b0;
            end
            CMD_SLEEP_WAKE: begin
                if (st.pin_valid && cfg.lock_on_sleep && (cfg.sleep_lock_seconds != '0)
                    && ((cfg.sleep_lock_seconds == TMO_IMMEDIATE)
                        || (item.elapsed_seconds >= 32'(cfg.sleep_lock_seconds)))) begin
                    st_next.locked = 1'b1;
                    screen         = 1'b1;
                end
            end
            CMD_IDLE_CHECK: begin
                if (st.pin_valid && cfg.idle_lock_enable && !st.locked
                    && (cfg.idle_lock_seconds != '0)
                    && (cfg.idle_lock_seconds != TMO_IMMEDIATE)
                    && (item.idle_ms >= 32'(cfg.idle_lock_ms))) begin
                    st_next.locked = 1'b1;
                    screen         = 1'b1;
                end
            end
            CMD_SECOND_TICK: begin
                if (st.lockout_left != '0) begin
                    st_next.lockout_left = st.lockout_left - 10'd1;
                end
            end
            CMD_POWER_UP: begin
                if (st.fail_count >= 8'(FAIL_THRESHOLD)) begin
                    st_next.lockout_left = lockout_for(st.fail_count);
                end
                if (st.pin_valid && cfg.lock_on_boot) begin
                    st_next.locked = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign result.ok            = ok;
    assign result.is_locked     = st_next.locked;
    assign result.pin_present   = st_next.pin_valid;
    assign result.failures      = st_next.fail_count;
    assign result.lockout_left  = st_next.lockout_left;
    assign result.screen_change = screen;

endmodule

// File: design/plc_checker.sv
module plc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input plc_pkg::out_item_t  m_data
);
    import plc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // nothing leaves the block right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a request taken while no result is held must reach m_valid through the input and result registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |-> ##2 m_valid)
        else $error("request not answered");

    // without a PIN the device cannot be locked and no failures can build up
    a_no_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.pin_present |->
            !m_data.is_locked && (m_data.failures == '0) && (m_data.lockout_left == '0))
        else $error("lock state without a stored PIN");

    // a policy lock implies a stored PIN and a locked device
    a_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.screen_change |-> m_data.is_locked && m_data.pin_present
            && !m_data.ok)
        else $error("screen change without lock");

endmodule

bind pin_lockout_controller_core plc_checker u_plc_checker (.*);

// File: verif/tb_pin_lockout_controller_core.sv
module tb_pin_lockout_controller_core;
    timeunit 1ns;
    timeprecision 1ps;

    import plc_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PRINT_CAP = 40;
    localparam logic [3:0] CMD_UNDEF_FIRST = 4'd9;
    localparam logic [3:0] CMD_UNDEF_LAST = 4'd15;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pin_lockout_controller_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // lock policy, as last written
    bit cfg_boot_lock, cfg_sleep_lock, cfg_idle_lock;
    logic [15:0] cfg_sleep_secs = '0;
    logic [15:0] cfg_idle_secs = '0;

    // controller state
    bit dev_locked, pin_set;
    logic [63:0] pin_store = '0;
    logic [3:0] pin_len = '0;
    logic [7:0] fail_cnt = '0;
    logic [9:0] lock_left = '0;

    in_item_t pending[$];
    out_item_t status_due[$];
    out_item_t want;
    bit s_fire;
    int send_gap_pct, stall_pct;
    int hold_req, hold_seen, hold_left;
    int mismatch_count, cycles, queued;

    // stimulus side: the PIN the generator believes is stored
    logic [63:0] gen_pin;
    logic [3:0] gen_len;

    function automatic logic [63:0] byte_ones(input logic [3:0] len);
        if (len >= 4'd8) return '1;
        return (64'd1 << (8 * int'(len))) - 64'd1;
    endfunction

    function automatic logic [9:0] penalty_secs(input logic [7:0] fails);
        int steps;
        if (fails < 8'(FAIL_THRESHOLD)) return '0;
        steps = int'(fails) - FAIL_THRESHOLD;
        if (steps > int'(LOCKOUT_MAX_SHIFT)) steps = int'(LOCKOUT_MAX_SHIFT);
        return LOCKOUT_BASE << steps;
    endfunction

    // verify with all side effects on the failure count and lockout
    function automatic bit try_pin(input logic [63:0] chars, input logic [3:0] len);
        if (!pin_set || lock_left != 0) return 1'b0;
        if (len == pin_len && len <= 4'd8 && ((chars ^ pin_store) & byte_ones(len)) == 64'd0) begin
            fail_cnt = '0;
            lock_left = '0;
            return 1'b1;
        end
        if (fail_cnt != FAIL_SATURATE) fail_cnt = fail_cnt + 8'd1;
        if (penalty_secs(fail_cnt) != 0) lock_left = penalty_secs(fail_cnt);
        return 1'b0;
    endfunction

    function automatic bit digits_ok(input logic [63:0] chars, input logic [3:0] len);
        if (len < MIN_PIN_CHARS || len > 4'(MAX_PIN_CHARS)) return 1'b0;
        for (int i = 0; i < PIN_BYTES; i++) begin
            if (i < int'(len) && (chars[i*8 +: 8] < CHAR_ZERO || chars[i*8 +: 8] > CHAR_NINE))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic out_item_t run_command(input in_item_t req);
        out_item_t res;
        bit good, screen;
        good = 1'b0;
        screen = 1'b0;
        case (req.command)
            CMD_VERIFY: good = try_pin(req.pin_chars, req.pin_length);
            CMD_SET: begin
                if (digits_ok(req.pin_chars, req.pin_length)) begin
                    pin_store = req.pin_chars & byte_ones(req.pin_length);
                    pin_len = req.pin_length;
                    pin_set = 1'b1;
                    fail_cnt = '0;
                    lock_left = '0;
                    good = 1'b1;
                end
            end
            CMD_CLEAR: begin
                if (!pin_set) begin
                    good = 1'b1;
                end else if (try_pin(req.pin_chars, req.pin_length)) begin
                    pin_set = 1'b0;
                    pin_store = '0;
                    pin_len = '0;
                    dev_locked = 1'b0;
                    good = 1'b1;
                end
            end
            CMD_LOCK: if (pin_set) dev_locked = 1'b1;
            CMD_UNLOCK: dev_locked = 1'b0;
            CMD_SLEEP_WAKE: begin
                if (pin_set && cfg_sleep_lock && cfg_sleep_secs != 0 &&
                    (cfg_sleep_secs == TMO_IMMEDIATE ||
                     req.elapsed_seconds >= {16'd0, cfg_sleep_secs})) begin
                    dev_locked = 1'b1;
                    screen = 1'b1;
                end
            end
            CMD_IDLE_CHECK: begin
                if (pin_set && cfg_idle_lock && !dev_locked && cfg_idle_secs != 0 &&
                    cfg_idle_secs != TMO_IMMEDIATE &&
                    64'(req.idle_ms) >= 64'(cfg_idle_secs) * 64'(MS_PER_SECOND)) begin
                    dev_locked = 1'b1;
                    screen = 1'b1;
                end
            end
            CMD_SECOND_TICK: if (lock_left != 0) lock_left = lock_left - 10'd1;
            CMD_POWER_UP: begin
                if (fail_cnt >= 8'(FAIL_THRESHOLD)) lock_left = penalty_secs(fail_cnt);
                if (pin_set && cfg_boot_lock) dev_locked = 1'b1;
            end
            default: ;
        endcase
        res.ok = good;
        res.is_locked = dev_locked;
        res.pin_present = pin_set;
        res.failures = fail_cnt;
        res.lockout_left = lock_left;
        res.screen_change = screen;
        return res;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
        mismatch_count++;
    endtask

    // request driver
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            status_due.push_back(run_command(s_data));
            s_fire = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_fire)) begin
            if (pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                s_data <= pending.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        s_fire = 1'b0;
    end

    // result side: random stalls plus an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (status_due.size() == 0) begin
                report("result with no request pending", 64'(m_data), 64'd0);
            end else begin
                want = status_due.pop_front();
                if (m_data.ok !== want.ok) report("ok", 64'(m_data.ok), 64'(want.ok));
                if (m_data.is_locked !== want.is_locked)
                    report("is_locked", 64'(m_data.is_locked), 64'(want.is_locked));
                if (m_data.pin_present !== want.pin_present)
                    report("pin_present", 64'(m_data.pin_present), 64'(want.pin_present));
                if (m_data.failures !== want.failures)
                    report("failures", 64'(m_data.failures), 64'(want.failures));
                if (m_data.lockout_left !== want.lockout_left)
                    report("lockout_left", 64'(m_data.lockout_left), 64'(want.lockout_left));
                if (m_data.screen_change !== want.screen_change)
                    report("screen_change", 64'(m_data.screen_change),
                           64'(want.screen_change));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_LOCK_ON_BOOT: cfg_boot_lock = val[0];
            CFG_LOCK_ON_SLEEP: cfg_sleep_lock = val[0];
            CFG_SLEEP_LOCK_SECONDS: cfg_sleep_secs = val;
            CFG_IDLE_LOCK_ENABLE: cfg_idle_lock = val[0];
            CFG_IDLE_LOCK_SECONDS: cfg_idle_secs = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_policy(input logic [15:0] boot, input logic [15:0] slp,
                              input logic [15:0] slp_secs, input logic [15:0] idl,
                              input logic [15:0] idl_secs);
        write_reg(CFG_LOCK_ON_BOOT, boot);
        write_reg(CFG_LOCK_ON_SLEEP, slp);
        write_reg(CFG_SLEEP_LOCK_SECONDS, slp_secs);
        write_reg(CFG_IDLE_LOCK_ENABLE, idl);
        write_reg(CFG_IDLE_LOCK_SECONDS, idl_secs);
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || s_valid || status_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic in_item_t mk(input logic [3:0] cmd, input logic [63:0] chars,
                                    input logic [3:0] len, input logic [31:0] el,
                                    input logic [31:0] ina);
        in_item_t r;
        r.command = cmd;
        r.pin_chars = chars;
        r.pin_length = len;
        r.elapsed_seconds = el;
        r.idle_ms = ina;
        return r;
    endfunction

    function automatic in_item_t noise_req(input logic [3:0] cmd);
        return mk(cmd, {$urandom, $urandom}, 4'($urandom_range(0, 15)), $urandom, $urandom);
    endfunction

    // digits in the low len bytes, junk above
    function automatic logic [63:0] digit_string(input logic [3:0] len);
        logic [63:0] v;
        v = {$urandom, $urandom};
        for (int i = 0; i < PIN_BYTES; i++) begin
            if (i < int'(len)) v[i*8 +: 8] = CHAR_ZERO + 8'($urandom_range(0, 9));
        end
        return v;
    endfunction

    function automatic logic [7:0] other_digit(input logic [7:0] d);
        return CHAR_ZERO + 8'((int'(d - CHAR_ZERO) + 1 + $urandom_range(0, 8)) % 10);
    endfunction

    task automatic push_random();
        in_item_t r;
        int unsigned pick, sel, pos, burst;
        logic [63:0] m;
        logic [31:0] edge_val;
        r = noise_req(CMD_VERIFY);
        pick = $urandom_range(0, 99);
        sel = $urandom_range(0, 99);
        if (pick < 31) begin
            if (pick >= 26) r.command = CMD_CLEAR;
            m = byte_ones(gen_len);
            if (sel < 55) begin
                r.pin_chars = (r.pin_chars & ~m) | (gen_pin & m);
                r.pin_length = gen_len;
            end else if (sel < 75) begin
                pos = $urandom_range(0, int'(gen_len) - 1);
                r.pin_chars = gen_pin;
                r.pin_chars[pos*8 +: 8] = other_digit(gen_pin[pos*8 +: 8]);
                r.pin_length = gen_len;
            end else if (sel < 88) begin
                r.pin_chars = gen_pin;
                r.pin_length = $urandom_range(0, 1) ? gen_len + 4'd1 : gen_len - 4'd1;
            end
        end else if (pick < 41) begin
            r.command = CMD_SET;
            if (sel < 60) begin
                gen_len = 4'($urandom_range(int'(MIN_PIN_CHARS), MAX_PIN_CHARS));
                gen_pin = digit_string(gen_len);
                r.pin_chars = gen_pin;
                r.pin_length = gen_len;
            end else if (sel < 80) begin
                r.pin_length = 4'($urandom_range(int'(MIN_PIN_CHARS), MAX_PIN_CHARS));
                r.pin_chars = digit_string(r.pin_length);
                pos = $urandom_range(0, int'(r.pin_length) - 1);
                case ($urandom_range(0, 2))
                    0: r.pin_chars[pos*8 +: 8] = CHAR_ZERO - 8'd1;
                    1: r.pin_chars[pos*8 +: 8] = CHAR_NINE + 8'd1;
                    default: r.pin_chars[pos*8 +: 8] = 8'($urandom);
                endcase
            end
        end else if (pick < 49) begin
            r.command = CMD_LOCK;
        end else if (pick < 56) begin
            r.command = CMD_UNLOCK;
        end else if (pick < 66 || pick < 76) begin
            // elapsed or inactive time placed around the policy threshold, or at zero, all ones or random
            if (pick < 66) begin
                r.command = CMD_SLEEP_WAKE;
                edge_val = {16'd0, cfg_sleep_secs};
            end else begin
                r.command = CMD_IDLE_CHECK;
                edge_val = 32'(cfg_idle_secs) * 32'(MS_PER_SECOND);
            end
            case (sel % 6)
                0: edge_val = '0;
                1: edge_val = edge_val - 32'd1;
                2: ;
                3: edge_val = edge_val + 32'd1;
                4: edge_val = '1;
                default: edge_val = $urandom;
            endcase
            if (pick < 66) r.elapsed_seconds = edge_val;
            else r.idle_ms = edge_val;
        end else if (pick < 92) begin
            burst = $urandom_range(1, 40);
            repeat (burst) pending.push_back(noise_req(CMD_SECOND_TICK));
            queued += burst;
            return;
        end else if (pick < 97) begin
            r.command = CMD_POWER_UP;
        end else begin
            r.command = 4'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
        end
        pending.push_back(r);
        queued++;
    endtask

    initial begin
        int ph;
        send_gap_pct = 0;
        stall_pct = 0;
        gen_len = 4'd4;
        gen_pin = 64'h34333231;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: sleep locks at once, idle locks after 2 s
        set_policy(16'd1, 16'd1, TMO_IMMEDIATE, 16'd1, 16'd2);
        pending.push_back(mk(CMD_VERIFY, 64'h34333231, 4'd4, '0, '0));
        pending.push_back(mk(CMD_CLEAR, 64'h34333231, 4'd4, '0, '0));
        pending.push_back(mk(CMD_LOCK, '0, '0, '0, '0));
        pending.push_back(mk(CMD_SLEEP_WAKE, '0, '0, '1, '0));
        pending.push_back(mk(CMD_SET, 64'h333231, 4'd3, '0, '0));
        pending.push_back(mk(CMD_SET, 64'h3837363534333231, 4'd9, '0, '0));
        pending.push_back(mk(CMD_SET, 64'h3A37363534333231, 4'd8, '0, '0));
        pending.push_back(mk(CMD_SET, 64'h3433322F, 4'd4, '0, '0));
        pending.push_back(mk(CMD_SET, 64'h3837363534333231, 4'd8, '0, '0));
        pending.push_back(mk(CMD_VERIFY, 64'h3837363534333231, 4'd15, '0, '0));
        pending.push_back(mk(CMD_VERIFY, 64'h3937363534333231, 4'd8, '0, '0));
        pending.push_back(mk(CMD_VERIFY, 64'h3837363534333231, 4'd8, '0, '0));
        pending.push_back(mk(CMD_SET, 64'hFFFFFFFF30303030, 4'd4, '0, '0));
        pending.push_back(mk(CMD_VERIFY, 64'hA5A5A5A530303030, 4'd4, '0, '0));
        pending.push_back(mk(CMD_IDLE_CHECK, '0, '0, '0, 32'd1999));
        pending.push_back(mk(CMD_IDLE_CHECK, '0, '0, '0, 32'd2000));
        pending.push_back(mk(CMD_IDLE_CHECK, '0, '0, '0, '1));
        pending.push_back(mk(CMD_UNLOCK, '0, '0, '0, '0));
        pending.push_back(mk(CMD_SLEEP_WAKE, '0, '0, '0, '0));
        pending.push_back(mk(CMD_SLEEP_WAKE, '0, '0, '0, '0));
        pending.push_back(mk(CMD_SECOND_TICK, '0, '0, '0, '0));
        pending.push_back(mk(CMD_POWER_UP, '0, '0, '0, '0));
        pending.push_back(mk(CMD_UNDEF_FIRST, '1, '1, '1, '1));
        pending.push_back(mk(CMD_UNDEF_LAST, '1, '1, '1, '1));
        pending.push_back(mk(CMD_CLEAR, 64'h30303030, 4'd4, '0, '0));
        wait_idle();

        // walk the failure count up to the longest lockout, waiting out each window but the last
        set_policy(16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        pending.push_back(mk(CMD_SET, 64'h38363432, 4'd4, '0, '0));
        for (int n = 0; n < 10; n++) begin
            pending.push_back(mk(CMD_VERIFY, 64'h39363432, 4'd4, $urandom, $urandom));
            wait_idle();
            if (n == 5 || n == 9) begin
                // refused during lockout, then power-up re-arms the full window
                pending.push_back(mk(CMD_VERIFY, 64'h38363432, 4'd4, '0, '0));
                pending.push_back(noise_req(CMD_SECOND_TICK));
                pending.push_back(noise_req(CMD_POWER_UP));
                wait_idle();
            end
            // the last window stays armed; a new PIN ends it below
            if (n < 9) begin
                for (int t = 0; t < int'(lock_left); t++)
                    pending.push_back(noise_req(CMD_SECOND_TICK));
            end
            wait_idle();
        end
        pending.push_back(mk(CMD_VERIFY, 64'h38363432, 4'd4, '0, '0));
        pending.push_back(mk(CMD_SET, 64'h38363432, 4'd4, '0, '0));
        pending.push_back(mk(CMD_VERIFY, 64'h38363432, 4'd4, '0, '0));
        pending.push_back(mk(CMD_UNLOCK, '0, '0, '0, '0));
        wait_idle();
        gen_len = 4'd4;
        gen_pin = 64'h38363432;

        for (ph = 0; ph < 5; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    send_gap_pct = 0;
                    stall_pct = 0;
                    set_policy(16'd1, 16'd1, TMO_IMMEDIATE, 16'd1, 16'd1);
                end
                1: begin
                    send_gap_pct = 70;
                    stall_pct = 0;
                    set_policy(16'd0, 16'd1, 16'd1, 16'd1, TMO_IMMEDIATE - 16'd1);
                end
                2: begin
                    send_gap_pct = 0;
                    stall_pct = 70;
                    set_policy(16'd1, 16'd0, 16'($urandom), 16'd0, TMO_IMMEDIATE);
                end
                3: begin
                    send_gap_pct = 35;
                    stall_pct = 35;
                    set_policy(16'd1, 16'd1, 16'd0, 16'd1, 16'd0);
                end
                default: begin
                    send_gap_pct = 35;
                    stall_pct = 35;
                    write_reg(CFG_NO_REG, 16'($urandom));
                    set_policy(16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom));
                end
            endcase
            queued = 0;
            while (queued < ITEMS_PER_PHASE) push_random();
            // hold the result side so the pipe backs up into the input
            if (ph == 0) hold_req++;
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
design/plc_pkg.sv
design/plc_cfg_regs.sv
design/plc_cmd_unit.sv
design/pin_lockout_controller_core.sv
design/plc_checker.sv
verif/tb_pin_lockout_controller_core.sv
